// ===== rtl/rc6_block_cipher_core_defines.svh =====
// ----------------------------------------------------------------------------
// RC6 core assertion macros
// Shared property macros for the checker attached to the core.
// ----------------------------------------------------------------------------
`ifndef RC6_BLOCK_CIPHER_CORE_DEFINES_SVH
`define RC6_BLOCK_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RC6_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rc6 same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RC6_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rc6 next-cycle check failed");

`endif

// ===== rtl/rc6_pkg.sv =====
// ----------------------------------------------------------------------------
// RC6 package
// Constants, codes, command/status structs and helper functions of the core.
// ----------------------------------------------------------------------------
package rc6_pkg;

    localparam int ROUNDS        = 20;
    localparam int MAX_KEY_WORDS = 8;
    localparam int TABLE_WORDS   = 2 * ROUNDS + 4;
    localparam int BANK_DEPTH    = TABLE_WORDS / 2;
    localparam int MIX_STEPS     = 3 * TABLE_WORDS;

    localparam int TI_W   = $clog2(TABLE_WORDS);
    localparam int BA_W   = $clog2(BANK_DEPTH);
    localparam int KJ_W   = $clog2(MAX_KEY_WORDS);
    localparam int STEP_W = $clog2(MIX_STEPS);
    localparam int RND_W  = $clog2(ROUNDS + 1);

    localparam logic [31:0] MAGIC_P = 32'hB7E15163;
    localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;
    localparam logic [4:0]  QMIX_ROT = 5'd5;
    localparam logic [4:0]  KS_ROT   = 5'd3;

    localparam logic [BA_W-1:0] LAST_ADDR = BA_W'(BANK_DEPTH - 1);

    // Opcodes
    localparam logic [1:0] OP_EXPAND  = 2'd0;
    localparam logic [1:0] OP_ENCRYPT = 2'd1;
    localparam logic [1:0] OP_DECRYPT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_KEY_LEN = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_LOAD,
        ST_KS_READ,
        ST_KS_MIXA,
        ST_KS_MIXB,
        ST_CP_READ,
        ST_CP_PRE,
        ST_CP_MUL,
        ST_CP_RND,
        ST_CP_POST,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO_OK,
        RES_ERROR,
        RES_DATA
    } kind_t;

    typedef struct packed {
        logic            load_key;
        logic            ks_mix_a;
        logic            ks_mix_b;
        logic            ks_first;
        logic [TI_W-1:0] ks_i;
        logic [KJ_W-1:0] ks_j;
        logic [BA_W-1:0] rk_addr;
        logic            load_blk;
        logic            pre;
        logic            mul;
        logic            rnd;
        logic            post;
        logic            decrypt;
        logic            out_load;
        logic            out_zero;
        logic            out_status;
    } cmd_t;

    typedef struct packed {
        logic [KJ_W-1:0] key_last;
    } stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

endpackage

// ===== rtl/rc6_block_cipher_core.sv =====
// Cipher path: key read, whitening, a multiply state then a mix state for each round,
// whitening and result load; the result can then be taken from the output register.
// Key expansion: key load, 132 mixing steps (read, mix A and mix B states), result load.
// Error and no-op results go straight to the result load. One item is in work at a time, so a
// new input is taken only once the result of the last one is loaded into the output register.
// Reset clears controller, key_ready and config registers; round key banks are not cleared.
// ----------------------------------------------------------------------------
// RC6-32/20 block cipher core
// Stream-in opcode and block, stream-out result block and status.
// ----------------------------------------------------------------------------
module rc6_block_cipher_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_low [63:0], block_high [127:64]
    input  logic [1:0]   s_tuser,   // opcode [1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_low [63:0], result_high [127:64]
    output logic         m_tuser    // status [0]
);
    import rc6_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rc6_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rc6_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .block_low   (s_tdata[63:0]),
        .block_high  (s_tdata[127:64]),
        .cmd         (cmd),
        .stat        (stat),
        .result_low  (m_tdata[63:0]),
        .result_high (m_tdata[127:64]),
        .status      (m_tuser)
    );

endmodule

// ===== rtl/rc6_ctrl.sv =====
// ----------------------------------------------------------------------------
// RC6 controller
// Sequences key expansion and the cipher rounds, owns key_ready and out valid.
// ----------------------------------------------------------------------------
module rc6_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     opcode,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  rc6_pkg::stat_t stat,
    output rc6_pkg::cmd_t  cmd
);
    import rc6_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TI_W-1:0]   i_reg, i_next;
    logic [KJ_W-1:0]   j_reg, j_next;
    logic [RND_W-1:0]  round_reg, round_next;
    logic              dec_reg, dec_next;
    kind_t             kind_reg, kind_next;
    logic              key_ready_reg, key_ready_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              last_round;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = m_valid_reg;
    assign last_round = dec_reg ? (round_reg == RND_W'(1)) : (round_reg == RND_W'(ROUNDS));

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            round_reg     <= '0;
            dec_reg       <= 1'b0;
            kind_reg      <= RES_ZERO_OK;
            key_ready_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            round_reg     <= round_next;
            dec_reg       <= dec_next;
            kind_reg      <= kind_next;
            key_ready_reg <= key_ready_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        round_next     = round_reg;
        dec_next       = dec_reg;
        kind_next      = kind_reg;
        key_ready_next = key_ready_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        cmd            = '0;
        cmd.ks_i       = i_reg;
        cmd.ks_j       = j_reg;
        cmd.ks_first   = (step_reg < STEP_W'(TABLE_WORDS));
        cmd.decrypt    = dec_reg;
        cmd.rk_addr    = i_reg[TI_W-1:1];

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    dec_next = (opcode == OP_DECRYPT);
                    case (opcode)
                        OP_EXPAND: begin
                            state_next = ST_KS_LOAD;
                        end
                        OP_ENCRYPT, OP_DECRYPT: begin
                            if (key_ready_reg) begin
                                cmd.load_blk = 1'b1;
                                state_next   = ST_CP_READ;
                            end else begin
                                kind_next  = RES_ERROR;
                                state_next = ST_OUT;
                            end
                        end
                        default: begin
                            kind_next  = RES_ZERO_OK;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_KS_LOAD: begin
                cmd.load_key = 1'b1;
                step_next    = '0;
                i_next       = '0;
                j_next       = '0;
                state_next   = ST_KS_READ;
            end
            ST_KS_READ: begin
                state_next = ST_KS_MIXA;
            end
            ST_KS_MIXA: begin
                cmd.ks_mix_a = 1'b1;
                state_next   = ST_KS_MIXB;
            end
            ST_KS_MIXB: begin
                cmd.ks_mix_b = 1'b1;
                i_next = (i_reg == TI_W'(TABLE_WORDS - 1)) ? '0 : i_reg + 1'b1;
                j_next = (j_reg == stat.key_last) ? '0 : j_reg + 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MIX_STEPS - 1)) begin
                    key_ready_next = 1'b1;
                    kind_next      = RES_ZERO_OK;
                    state_next     = ST_OUT;
                end else begin
                    state_next = ST_KS_READ;
                end
            end
            ST_CP_READ: begin
                cmd.rk_addr = dec_reg ? LAST_ADDR : '0;
                state_next  = ST_CP_PRE;
            end
            ST_CP_PRE: begin
                cmd.pre    = 1'b1;
                round_next = dec_reg ? RND_W'(ROUNDS) : RND_W'(1);
                state_next = ST_CP_MUL;
            end
            ST_CP_MUL: begin
                cmd.mul     = 1'b1;
                cmd.rk_addr = BA_W'(round_reg);
                state_next  = ST_CP_RND;
            end
            ST_CP_RND: begin
                cmd.rnd     = 1'b1;
                cmd.rk_addr = dec_reg ? '0 : LAST_ADDR;
                if (last_round) begin
                    state_next = ST_CP_POST;
                end else begin
                    round_next = dec_reg ? round_reg - 1'b1 : round_reg + 1'b1;
                    state_next = ST_CP_MUL;
                end
            end
            ST_CP_POST: begin
                cmd.post   = 1'b1;
                kind_next  = RES_DATA;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_zero   = (kind_reg != RES_DATA);
                    cmd.out_status = (kind_reg == RES_ERROR);
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rc6_dpath.sv =====
// ----------------------------------------------------------------------------
// RC6 datapath
// Config registers, round key banks, key buffer, block words and result.
// ----------------------------------------------------------------------------
module rc6_dpath (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [63:0]    cfg_wdata,
    input  logic [63:0]    block_low,
    input  logic [63:0]    block_high,
    input  rc6_pkg::cmd_t  cmd,
    output rc6_pkg::stat_t stat,
    output logic [63:0]    result_low,
    output logic [63:0]    result_high,
    output logic           status
);
    import rc6_pkg::*;

    logic [63:0] key_reg [4];
    logic [3:0]  len_reg;
    logic [3:0]  len_sat;
    logic [3:0]  len_eff;

    logic [31:0] bank_even [BANK_DEPTH];
    logic [31:0] bank_odd  [BANK_DEPTH];
    logic [31:0] rd_even_reg, rd_odd_reg;
    logic [31:0] lbuf_reg [MAX_KEY_WORDS];

    logic [31:0] ks_a_reg, ks_b_reg, init_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] t_prod_reg, u_prod_reg;
    logic [31:0] t_val, u_val;
    logic [31:0] ks_s, ks_a_new, ks_ab, ks_b_new;
    logic [31:0] m_src_t, m_src_u;

    logic [63:0] res_low_reg, res_high_reg;
    logic        status_reg;

    // Saturate the key length; an empty key counts as one zero word
    assign len_sat       = (len_reg > 4'(MAX_KEY_WORDS)) ? 4'(MAX_KEY_WORDS) : len_reg;
    assign len_eff       = (len_sat == 4'd0) ? 4'd1 : len_sat;
    assign stat.key_last = KJ_W'(len_eff - 4'd1);

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) key_reg[k] <= '0;
            len_reg <= 4'd4;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEY0:    key_reg[0] <= cfg_wdata;
                REG_KEY1:    key_reg[1] <= cfg_wdata;
                REG_KEY2:    key_reg[2] <= cfg_wdata;
                REG_KEY3:    key_reg[3] <= cfg_wdata;
                REG_KEY_LEN: len_reg    <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Key schedule mixing
    assign ks_s     = cmd.ks_first ? init_reg : (cmd.ks_i[0] ? rd_odd_reg : rd_even_reg);
    assign ks_a_new = rotl(ks_s + ks_a_reg + ks_b_reg, KS_ROT);
    assign ks_ab    = ks_a_reg + ks_b_reg;
    assign ks_b_new = rotl(lbuf_reg[cmd.ks_j] + ks_ab, ks_ab[4:0]);

    // Round key banks: even and odd entries, registered read
    always_ff @(posedge aclk) begin
        if (cmd.ks_mix_a && !cmd.ks_i[0]) bank_even[cmd.ks_i[TI_W-1:1]] <= ks_a_new;
        if (cmd.ks_mix_a &&  cmd.ks_i[0]) bank_odd[cmd.ks_i[TI_W-1:1]]  <= ks_a_new;
        rd_even_reg <= bank_even[cmd.rk_addr];
        rd_odd_reg  <= bank_odd[cmd.rk_addr];
    end

    // Key word buffer and schedule accumulators
    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            for (int n = 0; n < MAX_KEY_WORDS; n++) begin
                lbuf_reg[n] <= (4'(n) < len_sat) ? key_reg[n / 2][32 * (n % 2) +: 32] : '0;
            end
            ks_a_reg <= '0;
            ks_b_reg <= '0;
            init_reg <= MAGIC_P;
        end else begin
            if (cmd.ks_mix_a) begin
                ks_a_reg <= ks_a_new;
                if (cmd.ks_first) init_reg <= init_reg + MAGIC_Q;
            end
            if (cmd.ks_mix_b) begin
                ks_b_reg            <= ks_b_new;
                lbuf_reg[cmd.ks_j]  <= ks_b_new;
            end
        end
    end

    // Quadratic products; decryption takes them on the rotated words
    assign m_src_t = cmd.decrypt ? a_reg : b_reg;
    assign m_src_u = cmd.decrypt ? c_reg : d_reg;
    assign t_val   = rotl(t_prod_reg, QMIX_ROT);
    assign u_val   = rotl(u_prod_reg, QMIX_ROT);

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            t_prod_reg <= m_src_t * {m_src_t[30:0], 1'b1};
            u_prod_reg <= m_src_u * {m_src_u[30:0], 1'b1};
        end
    end

    // Block word updates
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        if (cmd.load_blk) begin
            a_next = block_low[31:0];
            b_next = block_low[63:32];
            c_next = block_high[31:0];
            d_next = block_high[63:32];
        end else if (cmd.pre) begin
            if (cmd.decrypt) begin
                a_next = a_reg - rd_even_reg;
                c_next = c_reg - rd_odd_reg;
            end else begin
                b_next = b_reg + rd_even_reg;
                d_next = d_reg + rd_odd_reg;
            end
        end else if (cmd.mul) begin
            if (cmd.decrypt) begin
                a_next = d_reg;
                b_next = a_reg;
                c_next = b_reg;
                d_next = c_reg;
            end
        end else if (cmd.rnd) begin
            if (cmd.decrypt) begin
                c_next = rotr(c_reg - rd_odd_reg, t_val[4:0]) ^ u_val;
                a_next = rotr(a_reg - rd_even_reg, u_val[4:0]) ^ t_val;
            end else begin
                a_next = c_reg;
                b_next = rotl(c_reg ^ u_val, t_val[4:0]) + rd_odd_reg;
                c_next = d_reg;
                d_next = rotl(a_reg ^ t_val, u_val[4:0]) + rd_even_reg;
                a_next = b_reg;
            end
        end else if (cmd.post) begin
            if (cmd.decrypt) begin
                b_next = b_reg - rd_even_reg;
                d_next = d_reg - rd_odd_reg;
            end else begin
                a_next = a_reg + rd_even_reg;
                c_next = c_reg + rd_odd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_low_reg  <= cmd.out_zero ? '0 : {b_reg, a_reg};
            res_high_reg <= cmd.out_zero ? '0 : {d_reg, c_reg};
            status_reg   <= cmd.out_status;
        end
    end

    assign result_low  = res_low_reg;
    assign result_high = res_high_reg;
    assign status      = status_reg;

endmodule

// ===== rtl/rc6_chk.sv =====
// ----------------------------------------------------------------------------
// RC6 port checker
// Watches the core's stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "rc6_block_cipher_core_defines.svh"

module rc6_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    // Stalled result holds
    `RC6_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One item at a time: ready drops after each input transaction
    `RC6_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Error status carries zero data
    `RC6_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 128'd0)

endmodule

bind rc6_block_cipher_core rc6_chk u_rc6_chk (.*);
